### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Types and constants of the Bezier curve evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int COORD_W  = 32;
   localparam int PCNT_W   = 5;
   localparam int IDX_W    = 4;
   localparam int TPARAM_W = 17;
   localparam int PT_AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CYC_W    = ($clog2(MAX_POINTS + 1) > 3) ? $clog2(MAX_POINTS + 1) : 3;
   localparam int T_W      = T_FRAC_BITS + 1;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = DIFF_W + T_W + 1;

   // last cycle count of a level never drops below the interpolation depth
   localparam int LEVEL_LAST_MIN = 4;

   localparam logic [T_W-1:0]    T_ONE  = T_W'(1) << T_FRAC_BITS;
   localparam logic [PROD_W-1:0] T_HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

   localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(2);
   localparam logic [PCNT_W-1:0] PCNT_MIN   = PCNT_W'(2);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic [IDX_W-1:0]           point_index;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic signed [COORD_W-1:0]  z_coord;
      logic [TPARAM_W-1:0]        t_param;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  x_out;
      logic signed [COORD_W-1:0]  y_out;
      logic signed [COORD_W-1:0]  z_out;
      logic                       error_flag;
   } rsp_item_type;

   typedef struct packed {
      logic             pt_we;
      logic             load_t;
      logic             rd_en;
      logic             rd_first;
      logic             rd_src_pts;
      logic [PT_AW-1:0] rd_addr;
      logic             load_rsp;
      logic             rsp_err;
   } dp_cmd_type;

endpackage

### design/bce_lane.sv
// ----------------------------------------------------------------------------
// bce_lane
// One coordinate lane: control point store, working store and interpolator.
// ----------------------------------------------------------------------------
module bce_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  bce_pkg::dp_cmd_type               cmd,
   input  logic [bce_pkg::PT_AW-1:0]         wr_addr,
   input  logic signed [bce_pkg::COORD_W-1:0] wr_data,
   input  logic [bce_pkg::T_W-1:0]           t_val,
   output logic signed [bce_pkg::COORD_W-1:0] result
);

   logic signed [bce_pkg::COORD_W-1:0] pts_mem  [bce_pkg::MAX_POINTS];
   logic signed [bce_pkg::COORD_W-1:0] work_mem [bce_pkg::MAX_POINTS];

   logic signed [bce_pkg::COORD_W-1:0] pts_rd_ff, work_rd_ff;
   logic                               v0_ff, first0_ff, src0_ff;
   logic [bce_pkg::PT_AW-1:0]          addr0_ff;
   logic signed [bce_pkg::COORD_W-1:0] prev_ff;

   logic                               v1_ff;
   logic signed [bce_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [bce_pkg::COORD_W-1:0] a1_ff;
   logic [bce_pkg::PT_AW-1:0]          addr1_ff;

   logic                               v2_ff;
   logic signed [bce_pkg::PROD_W-1:0]  prod_ff;
   logic signed [bce_pkg::COORD_W-1:0] a2_ff;
   logic [bce_pkg::PT_AW-1:0]          addr2_ff;

   logic signed [bce_pkg::COORD_W-1:0] result_ff;

   logic signed [bce_pkg::COORD_W-1:0] rd_data;
   logic signed [bce_pkg::DIFF_W-1:0]  diff_in;
   logic signed [bce_pkg::PROD_W-1:0]  prod_in;
   logic signed [bce_pkg::PROD_W-1:0]  rnd;
   logic signed [bce_pkg::PROD_W-1:0]  step;
   logic signed [bce_pkg::COORD_W-1:0] res_in;

   assign rd_data = src0_ff ? pts_rd_ff : work_rd_ff;
   assign diff_in = $signed({rd_data[bce_pkg::COORD_W-1], rd_data})
                  - $signed({prev_ff[bce_pkg::COORD_W-1], prev_ff});
   assign prod_in = diff_ff * $signed({1'b0, t_val});
   assign rnd     = prod_ff + $signed(bce_pkg::T_HALF);
   assign step    = rnd >>> bce_pkg::T_FRAC_BITS;
   assign res_in  = a2_ff + bce_pkg::COORD_W'(step);

   // stores: one write port each, registered read
   always_ff @(posedge clock) begin
      if (cmd.pt_we) begin
         pts_mem[wr_addr] <= wr_data;
      end
      if (v2_ff) begin
         work_mem[addr2_ff] <= res_in;
      end
      if (cmd.rd_en) begin
         pts_rd_ff  <= pts_mem[cmd.rd_addr];
         work_rd_ff <= work_mem[cmd.rd_addr];
      end
   end

   // pipeline valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.rd_en;
         v1_ff <= v0_ff && !first0_ff;
         v2_ff <= v1_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      first0_ff <= cmd.rd_first;
      src0_ff   <= cmd.rd_src_pts;
      addr0_ff  <= cmd.rd_addr;
      if (v0_ff) begin
         prev_ff  <= rd_data;
         diff_ff  <= diff_in;
         a1_ff    <= prev_ff;
         addr1_ff <= addr0_ff - bce_pkg::PT_AW'(1);
      end
      prod_ff  <= prod_in;
      a2_ff    <= a1_ff;
      addr2_ff <= addr1_ff;
      if (v2_ff) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;

endmodule

### design/bce_datapath.sv
// ----------------------------------------------------------------------------
// bce_datapath
// Three coordinate lanes, parameter register and result register.
// ----------------------------------------------------------------------------
module bce_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bce_pkg::dp_cmd_type   cmd,
   input  bce_pkg::req_item_type req_data,
   output bce_pkg::rsp_item_type rsp_data
);

   logic [bce_pkg::T_W-1:0]            t_ff, t_raw, t_in;
   logic [bce_pkg::PT_AW-1:0]          wr_addr;
   logic signed [bce_pkg::COORD_W-1:0] x_res, y_res, z_res;
   bce_pkg::rsp_item_type              rsp_ff, rsp_in;

   assign wr_addr = bce_pkg::PT_AW'(req_data.point_index);

   // saturate the parameter at 1.0
   assign t_raw = bce_pkg::T_W'(req_data.t_param);
   assign t_in  = (t_raw > bce_pkg::T_ONE) ? bce_pkg::T_ONE : t_raw;

   always_comb begin
      rsp_in.error_flag = cmd.rsp_err;
      if (cmd.rsp_err) begin
         rsp_in.x_out = '0;
         rsp_in.y_out = '0;
         rsp_in.z_out = '0;
      end else begin
         rsp_in.x_out = x_res;
         rsp_in.y_out = y_res;
         rsp_in.z_out = z_res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_t) begin
         t_ff <= t_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   bce_lane u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (req_data.x_coord),
      .t_val   (t_ff),
      .result  (x_res)
   );

   bce_lane u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (req_data.y_coord),
      .t_val   (t_ff),
      .result  (y_res)
   );

   bce_lane u_lane_z (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (req_data.z_coord),
      .t_val   (t_ff),
      .result  (z_res)
   );

   assign rsp_data = rsp_ff;

endmodule

### design/bce_ctrl.sv
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: accepts requests, walks the interpolation levels, issues results.
// ----------------------------------------------------------------------------
module bce_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bce_pkg::req_item_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        csr_we,
   input  logic [bce_pkg::PCNT_W-1:0]  csr_wdata,
   output bce_pkg::dp_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [bce_pkg::PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [bce_pkg::CYC_W-1:0]   m_ff, m_in;
   logic [bce_pkg::CYC_W-1:0]   cyc_ff, cyc_in;
   logic                        src_pts_ff, src_pts_in;
   logic                        err_ff, err_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        accept;
   logic [31:0]                 n_use;
   logic [bce_pkg::CYC_W-1:0]   lvl_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign n_use = (32'(pcnt_ff) > 32'(bce_pkg::MAX_POINTS)) ? 32'(bce_pkg::MAX_POINTS)
                                                           : 32'(pcnt_ff);
   assign lvl_last = (m_ff > bce_pkg::CYC_W'(bce_pkg::LEVEL_LAST_MIN)) ? m_ff
                   : bce_pkg::CYC_W'(bce_pkg::LEVEL_LAST_MIN);

   always_comb begin
      state_in     = state_ff;
      pcnt_in      = csr_we ? csr_wdata : pcnt_ff;
      m_in         = m_ff;
      cyc_in       = cyc_ff;
      src_pts_in   = src_pts_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd          = '0;
      cmd.rd_addr  = cyc_ff[bce_pkg::PT_AW-1:0];
      cmd.rd_first = (cyc_ff == '0);
      cmd.rd_src_pts = src_pts_ff;
      cmd.rsp_err  = err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == bce_pkg::REQ_WRITE) begin
                  cmd.pt_we = (32'(req_data.point_index) < 32'(bce_pkg::MAX_POINTS));
               end else begin
                  cmd.load_t = 1'b1;
                  cyc_in     = '0;
                  src_pts_in = 1'b1;
                  m_in       = bce_pkg::CYC_W'(n_use - 32'd1);
                  if (pcnt_ff < bce_pkg::PCNT_MIN) begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     err_in   = 1'b0;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            // read m+1 entries, then pad so the next level sees finished writes
            cmd.rd_en = (cyc_ff <= m_ff);
            if (cyc_ff == lvl_last) begin
               cyc_in     = '0;
               src_pts_in = 1'b0;
               if (m_ff == bce_pkg::CYC_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  m_in = m_ff - bce_pkg::CYC_W'(1);
               end
            end else begin
               cyc_in = cyc_ff + bce_pkg::CYC_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcnt_ff      <= bce_pkg::PCNT_RESET;
         m_ff         <= '0;
         cyc_ff       <= '0;
         src_pts_ff   <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcnt_ff      <= pcnt_in;
         m_ff         <= m_in;
         cyc_ff       <= cyc_in;
         src_pts_ff   <= src_pts_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/bezier_curve_evaluator_top.sv
// Write transfer: no result; the next request can be taken next cycle.
// Evaluate over n points: levels m = n-1 down to 1 each read m+1 entries, then pad
// so each level sees finished writes; the result loads when the output register is free.
// The walk is set by each lane's one working store read port and the 4-stage interpolator.
// Fewer than two points: error result, no level is walked.
// Reset clears control and sets point_count to 2; control point stores are not cleared.
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_top
// De Casteljau evaluation of a 3D Bezier curve over stored control points.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bce_pkg::req_item_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bce_pkg::rsp_item_type       rsp_data,
   input  logic                        csr_we,
   input  logic [bce_pkg::PCNT_W-1:0]  csr_wdata
);

   // Command bundle from the sequencer to the lanes: point store writes on a
   // write transfer, a parameter load on an evaluate, one read per cycle while a
   // level streams, and the result register load once the last level has retired.
   bce_pkg::dp_cmd_type cmd;

   // Sequencer: holds point_count, walks levels n-1 down to 1 and owns the
   // response valid. A result waits in the output register while the next
   // request is taken.
   bce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   // Datapath: three lanes run in lockstep, one interpolation each per cycle while a level
   // streams; the first level reads the point store, later levels the working store.
   bce_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

### design/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks of the Bezier curve evaluator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bce_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input bce_pkg::req_item_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input bce_pkg::rsp_item_type rsp_data
);

   // a pending result holds until transfer
   `BCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

   // error results carry zero coordinates
   `BCE_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.error_flag, rsp_data.x_out == '0 && rsp_data.y_out == '0 && rsp_data.z_out == '0, "error result with nonzero coordinates")

   // a write finishes in the transfer cycle
   `BCE_ASSERT_NEXT(a_write_fast, req_valid && req_ready && req_data.req_type == bce_pkg::REQ_WRITE, req_ready, "write request stalled the input")

   // an evaluate occupies the block
   `BCE_ASSERT_NEXT(a_eval_busy, req_valid && req_ready && req_data.req_type == bce_pkg::REQ_EVAL, !req_ready, "evaluate did not start")

   // a new result only appears at the end of an evaluate
   `BCE_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), !$past(req_ready), "result appeared without an evaluate")

endmodule

bind bezier_curve_evaluator_top bce_checker u_bce_checker (.*);
